[rtl/core/edpa_pkg.sv]
// Package for the electrode dipole potential accumulator.
// Holds the beat structs, size constants and the shared rounding helper.
// No dependencies.
`default_nettype none
package edpa_pkg;

  localparam int unsigned ELECTRODE_COUNT = 16;
  localparam int unsigned SUM_W = 32;
  localparam int unsigned WIDE_W = 64;
  localparam int unsigned ROOT_W = 32;

  typedef struct packed {
    logic [3:0]         electrode_index;
    logic [7:0]         electrode_row;
    logic [7:0]         electrode_col;
    logic [7:0]         electrode_height;
    logic [23:0]        dipole_x;
    logic [23:0]        dipole_y;
    logic signed [15:0] heading_x;
    logic signed [15:0] heading_y;
    logic               dipole_active;
    logic               clear_before;
  } req_t;

  typedef struct packed {
    logic [3:0]         result_index;
    logic signed [31:0] potential_sum;
    logic               applied;
    logic               saturated;
  } res_t;

  // Divide by 2^14, rounding to nearest with ties away from zero.
  function automatic logic signed [47:0] round14(logic signed [47:0] v);
    logic [47:0] mag;
    logic [47:0] r;
    mag = v[47] ? 48'(-v) : 48'(v);
    r = (mag + 48'd8192) >> 14;
    return v[47] ? -$signed(r) : $signed(r);
  endfunction

endpackage
`default_nettype wire

[rtl/core/electrode_dipole_potential_accumulate.sv]
// Top level of the electrode dipole potential accumulator: APB register,
// sequencer, and the potential store. Depends on edpa_pkg, edpa_ram,
// edpa_sqrt and edpa_div.
//
//   Channel  Ports                        Beat
//   config   psel/penable/pwrite/paddr    grid_gap_mm at byte address 0
//   input    start, busy, req_i           one electrode/dipole item
//   result   done_o, res_o                one result, one cycle, no stall
//
// An item that adds a contribution holds busy through seven setup states, two
// 32-step square roots and two 64-step divisions in the shared units (each
// followed by its done flag), and four more states (D2A, D2B, ACC, DONE). A
// skipped item goes from READ straight to DONE; one with zero distance goes
// from D2B to DONE after the first root. The next item is accepted in the idle
// cycle after the result. Reset clears the store through per-entry valid bits,
// so no clearing pass is needed. The receiver cannot stall; busy stays high
// from acceptance until the result cycle ends.
`default_nettype none
module electrode_dipole_potential_accumulate #(
  parameter int unsigned ELECTRODE_COUNT = edpa_pkg::ELECTRODE_COUNT
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [0:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic      [31:0]     prdata,
  output logic                 pready,
  input  wire logic            start,
  output logic                 busy,
  input  wire edpa_pkg::req_t  req_i,
  output logic                 done_o,
  output edpa_pkg::res_t       res_o
);

  localparam int unsigned AW = (ELECTRODE_COUNT > 1) ? $clog2(ELECTRODE_COUNT) : 1;
  localparam int unsigned W = edpa_pkg::WIDE_W;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_READ  = 16'h0002,
    S_MULA  = 16'h0004,
    S_ALONG = 16'h0008,
    S_PROJ  = 16'h0010,
    S_EXY   = 16'h0020,
    S_SQ    = 16'h0040,
    S_P2    = 16'h0080,
    S_SQRT1 = 16'h0100,
    S_D2A   = 16'h0200,
    S_D2B   = 16'h0400,
    S_SQRT2 = 16'h0800,
    S_DIV1  = 16'h1000,
    S_DIV2  = 16'h2000,
    S_ACC   = 16'h4000,
    S_DONE  = 16'h8000
  } state_e;

  state_e state_q, state_d;

  logic [7:0] gap_q;
  logic [ELECTRODE_COUNT-1:0] valid_q;

  edpa_pkg::req_t req_q;
  logic inrange_q, rdvalid_q;
  logic [AW-1:0] addr_q, rd_addr;
  logic [7:0] idx_ext;
  logic [31:0] ram_rdata;
  logic ram_we;

  logic signed [25:0] dx_q, dy_q;
  logic signed [41:0] mx_q, my_q;
  logic signed [29:0] along_q;
  logic signed [45:0] ax_q, ay_q;
  logic signed [31:0] ex_q, ey_q;
  logic [63:0] exsq_q, eysq_q;
  logic [31:0] hsq_q;
  logic [31:0] perp_q;
  logic [63:0] asq_q, psq_q, d2_q;
  logic signed [35:0] n_q;
  logic signed [31:0] sum_q;
  logic applied_q, sat_q;

  logic [15:0] cg, rg, h8;
  logic signed [47:0] along_w, rx_w, ry_w, next_w, sum_w, c_w;
  logic [63:0] p2_w, d2_w;
  logic signed [35:0] n_w;
  logic [35:0] mag_w;

  logic sq_start, sq_done, dv_start, dv_done;
  logic [W-1:0] sq_arg, dv_num, dv_den, dv_quot;
  logic [31:0] sq_root;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {24'd0, gap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      gap_q <= pwdata[7:0];
    end
  end

  // Store.
  assign idx_ext = {4'd0, req_i.electrode_index};
  assign rd_addr = idx_ext[AW-1:0];
  assign ram_we = (state_q == S_DONE) && inrange_q;

  edpa_ram #(
    .WIDTH (32),
    .DEPTH (ELECTRODE_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (sum_q),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[addr_q] <= 1'b1;
    end
  end

  // Shared arithmetic units.
  edpa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .arg_i   (sq_arg),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  edpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_num),
    .divisor_i  (dv_den),
    .done_o     (dv_done),
    .quot_o     (dv_quot)
  );

  always_comb begin
    cg = req_q.electrode_col * gap_q;
    rg = req_q.electrode_row * gap_q;
    h8 = {req_q.electrode_height, 8'd0};
    along_w = edpa_pkg::round14(48'(mx_q) + 48'(my_q));
    rx_w = edpa_pkg::round14(48'(ax_q));
    ry_w = edpa_pkg::round14(48'(ay_q));
    p2_w = exsq_q + eysq_q + {32'd0, hsq_q};
    d2_w = asq_q + psq_q;
    n_w = $signed(36'(along_q)) * 36'sd10 - $signed({4'd0, perp_q});
    mag_w = n_q[35] ? 36'(-n_q) : 36'(n_q);
    sum_w = 48'(sum_q);
    c_w = $signed({1'b0, dv_quot[46:0]});
    next_w = n_q[35] ? (sum_w - c_w) : (sum_w + c_w);

    sq_start = (state_q == S_P2) || ((state_q == S_D2B) && (d2_w != '0));
    sq_arg = (state_q == S_P2) ? p2_w : d2_w;
    dv_start = ((state_q == S_SQRT2) && sq_done) || ((state_q == S_DIV1) && dv_done);
    if (state_q == S_SQRT2) begin
      dv_num = {mag_w[32:0], 31'd0};
      dv_den = {32'd0, sq_root};
    end else begin
      dv_num = (dv_quot << 4) + (dv_quot << 1);
      dv_den = (d2_q << 2) + d2_q;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_READ;
      S_READ: begin
        if (!inrange_q || !req_q.dipole_active || gap_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_MULA;
        end
      end
      S_MULA:  state_d = S_ALONG;
      S_ALONG: state_d = S_PROJ;
      S_PROJ:  state_d = S_EXY;
      S_EXY:   state_d = S_SQ;
      S_SQ:    state_d = S_P2;
      S_P2:    state_d = S_SQRT1;
      S_SQRT1: if (sq_done) state_d = S_D2A;
      S_D2A:   state_d = S_D2B;
      S_D2B:   state_d = (d2_w == '0) ? S_DONE : S_SQRT2;
      S_SQRT2: if (sq_done) state_d = S_DIV1;
      S_DIV1:  if (dv_done) state_d = S_DIV2;
      S_DIV2:  if (dv_done) state_d = S_ACC;
      S_ACC:   state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_q <= req_i;
          inrange_q <= 32'(req_i.electrode_index) < ELECTRODE_COUNT;
          addr_q <= rd_addr;
          rdvalid_q <= valid_q[rd_addr];
          applied_q <= 1'b0;
          sat_q <= 1'b0;
        end
      end
      S_READ: begin
        sum_q <= (inrange_q && rdvalid_q && !req_q.clear_before) ? ram_rdata : '0;
        dx_q <= $signed({2'd0, cg, 8'd0}) - $signed({2'd0, req_q.dipole_x});
        dy_q <= $signed({2'd0, rg, 8'd0}) - $signed({2'd0, req_q.dipole_y});
      end
      S_MULA: begin
        mx_q <= 42'(dx_q) * 42'(req_q.heading_x);
        my_q <= 42'(dy_q) * 42'(req_q.heading_y);
      end
      S_ALONG: along_q <= along_w[29:0];
      S_PROJ: begin
        ax_q <= 46'(along_q) * 46'(req_q.heading_x);
        ay_q <= 46'(along_q) * 46'(req_q.heading_y);
      end
      S_EXY: begin
        ex_q <= 32'(dx_q) - rx_w[31:0];
        ey_q <= 32'(dy_q) - ry_w[31:0];
      end
      S_SQ: begin
        exsq_q <= 64'(ex_q) * 64'(ex_q);
        eysq_q <= 64'(ey_q) * 64'(ey_q);
        hsq_q <= h8 * h8;
      end
      S_SQRT1: if (sq_done) perp_q <= sq_root;
      S_D2A: begin
        asq_q <= 64'(along_q) * 64'(along_q);
        psq_q <= perp_q * perp_q;
      end
      S_D2B: begin
        d2_q <= d2_w;
        n_q <= n_w;
      end
      S_DIV2: begin
        if (dv_done) begin
          applied_q <= 1'b1;
          if (next_w > 48'sd2147483647) begin
            sum_q <= 32'h7FFF_FFFF;
            sat_q <= 1'b1;
          end else if (next_w < -48'sd2147483648) begin
            sum_q <= 32'h8000_0000;
            sat_q <= 1'b1;
          end else begin
            sum_q <= next_w[31:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign res_o.result_index = req_q.electrode_index;
  assign res_o.potential_sum = sum_q;
  assign res_o.applied = applied_q;
  assign res_o.saturated = sat_q;

endmodule
`default_nettype wire

[rtl/core/edpa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module edpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/core/edpa_sqrt.sv]
// Iterative integer square root, two operand bits per cycle.
// Depends on edpa_pkg for the word widths.
`default_nettype none
module edpa_sqrt (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [edpa_pkg::WIDE_W-1:0]  arg_i,
  output logic                              done_o,
  output logic      [edpa_pkg::ROOT_W-1:0]  root_o
);

  localparam int unsigned W = edpa_pkg::WIDE_W;

  logic         busy_q, busy_d, done_q, done_d;
  logic [W-1:0] n_q, n_d, res_q, res_d, bit_q, bit_d;
  logic [W-1:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    n_d = n_q;
    res_d = res_q;
    bit_d = bit_q;
    trial = res_q + bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      n_d = arg_i;
      res_d = '0;
      bit_d = W'(1) << (W - 2);
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_d = n_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[edpa_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

[rtl/core/edpa_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on edpa_pkg for the word width.
`default_nettype none
module edpa_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [edpa_pkg::WIDE_W-1:0]  dividend_i,
  input  wire logic [edpa_pkg::WIDE_W-1:0]  divisor_i,
  output logic                              done_o,
  output logic      [edpa_pkg::WIDE_W-1:0]  quot_o
);

  localparam int unsigned W = edpa_pkg::WIDE_W;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  num_q, num_d, den_q, den_d, quo_q, quo_d;
  logic [W:0]    rem_q, rem_d, shifted;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    num_d = num_q;
    den_d = den_q;
    quo_d = quo_q;
    rem_d = rem_q;
    shifted = {rem_q[W-1:0], num_q[W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = '0;
      num_d = dividend_i;
      den_d = divisor_i;
      quo_d = '0;
      rem_d = '0;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire
